// ===== hdl/rnsb_pkg.sv =====
`timescale 1ns / 1ps

package rnsb_pkg;

    localparam int DIM_W      = 11;
    localparam int STR_W      = 13;
    localparam int OFS_W      = 24;
    localparam int PIX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int MAX_OUT_HEIGHT_DEF = 1280;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    localparam logic [PIX_W-1:0] HALF_MASK = 16'h7BEF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_CW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SSTRIDE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DSTRIDE = 3'd7;

    // input word modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // result word kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // command codes between front and back
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] source_width;
        logic [DIM_W-1:0] source_height;
        logic [DIM_W-1:0] output_width;
        logic [DIM_W-1:0] output_height;
        logic             rotate_clockwise;
        logic             scanlines_on;
        logic [STR_W-1:0] source_stride;
        logic [STR_W-1:0] dest_stride;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0] code;
        logic [PIX_W-1:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic             kind;
        logic [OFS_W-1:0] source_offset;
        logic [OFS_W-1:0] dest_offset;
        logic [PIX_W-1:0] pixel_out;
        logic             frame_done;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] quotient;
        logic [DIM_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== hdl/rnsb_fifo.sv =====
`timescale 1ns / 1ps

// small register queue, first word shown while not empty
module rnsb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/rnsb_front.sv =====
`timescale 1ns / 1ps

// accepts input words, sorts them into pixel / start / empty-frame commands
module rnsb_front #(
    parameter int MAX_OUT_HEIGHT = rnsb_pkg::MAX_OUT_HEIGHT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      mode,
    input  logic [rnsb_pkg::PIX_W-1:0] pixel_in,
    input  rnsb_pkg::cfg_t            cfg,
    output logic                      cmd_valid,
    output rnsb_pkg::cmd_t            cmd,
    input  logic                      cmd_pop
);

    localparam int LIM_W = rnsb_pkg::DIM_W + 2;

    rnsb_pkg::cmd_t cmd_in;
    logic           bad_size;
    logic           cmd_empty;

    // user keeps sizes stable while a start waits (not enforced here)
    assign bad_size = (cfg.source_width == '0) || (cfg.source_height == '0)
                   || (cfg.output_width == '0) || (cfg.output_height == '0)
                   || ({2'b00, cfg.output_height} > LIM_W'(MAX_OUT_HEIGHT));

    always_comb
    begin
        cmd_in.pixel = pixel_in;
        if (mode == rnsb_pkg::MODE_PIXEL)
        begin
            cmd_in.code = rnsb_pkg::CMD_PIXEL;
        end
        else if (bad_size)
        begin
            cmd_in.code = rnsb_pkg::CMD_EMPTY;
        end
        else
        begin
            cmd_in.code = rnsb_pkg::CMD_START;
        end
    end

    rnsb_fifo #(
        .WIDTH ($bits(rnsb_pkg::cmd_t)),
        .DEPTH (rnsb_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule

// ===== hdl/rnsb_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module rnsb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  rnsb_pkg::div_req_t  req,
    output rnsb_pkg::div_rsp_t  rsp
);

    localparam int W  = rnsb_pkg::DIM_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hdl/rnsb_back.sv =====
`timescale 1ns / 1ps

// frame sequencer: walks destination pixels, keeps source row/column as
// quotient+remainder accumulators, builds read and write words
module rnsb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  rnsb_pkg::cfg_t cfg,
    input  logic           cmd_valid,
    input  rnsb_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_push,
    output rnsb_pkg::res_t res_word,
    input  logic           res_full,
    output logic           active
);

    localparam int W  = rnsb_pkg::DIM_W;
    localparam int OW = rnsb_pkg::OFS_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MARK = 3'd1;
    localparam logic [2:0] ST_DIVX = 3'd2;
    localparam logic [2:0] ST_DIVY = 3'd3;
    localparam logic [2:0] ST_INIT = 3'd4;
    localparam logic [2:0] ST_RD   = 3'd5;
    localparam logic [2:0] ST_WR   = 3'd6;

    typedef struct packed {
        logic [W-1:0] q;
        logic [W-1:0] r;
    } acc_t;

    function automatic acc_t step_up(acc_t a, logic [W-1:0] qs, logic [W-1:0] rs,
                                     logic [W-1:0] d);
        acc_t       o;
        logic [W:0] t;
        t = {1'b0, a.r} + {1'b0, rs};
        if (t >= {1'b0, d})
        begin
            o.q = a.q + qs + 1'b1;
            o.r = W'(t - {1'b0, d});
        end
        else
        begin
            o.q = a.q + qs;
            o.r = t[W-1:0];
        end
        return o;
    endfunction

    function automatic acc_t step_down(acc_t a, logic [W-1:0] qs, logic [W-1:0] rs,
                                       logic [W-1:0] d);
        acc_t       o;
        logic [W:0] t;
        t = {1'b0, a.r} - {1'b0, rs};
        if (t[W])
        begin
            o.q = a.q - qs - 1'b1;
            o.r = W'(t + {1'b0, d});
        end
        else
        begin
            o.q = a.q - qs;
            o.r = t[W-1:0];
        end
        return o;
    endfunction

    logic [2:0]              state_reg, state_next;
    logic                    active_reg, active_next;
    logic [rnsb_pkg::PIX_W-1:0] pix_reg, pix_next;
    rnsb_pkg::cfg_t          f_reg, f_next;
    logic                    scan_reg, scan_next;
    acc_t                    kx_reg, kx_next;   // sw / ow
    acc_t                    ky_reg, ky_next;   // sh / oh
    acc_t                    x_reg, x_next;
    acc_t                    y_reg, y_next;
    acc_t                    ys_reg, ys_next;   // y at column 0
    logic [W-1:0]            row_reg, row_next;
    logic [W-1:0]            col_reg, col_next;

    rnsb_pkg::div_req_t      div_req;
    rnsb_pkg::div_rsp_t      div_rsp;

    rnsb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic [OW-1:0] src_ofs;
    logic [OW-1:0] dst_ofs;
    logic          dark;
    logic          row_last;
    logic          col_last;
    acc_t          ax_top;
    acc_t          ay_top;
    acc_t          zero_acc;

    assign zero_acc = '0;
    assign src_ofs  = OW'(y_reg.q) * OW'(f_reg.source_stride) + OW'(x_reg.q);
    assign dst_ofs  = OW'(row_reg) * OW'(f_reg.dest_stride) + OW'(col_reg);
    // next landscape row maps to another source row
    assign dark     = scan_reg && ((ky_reg.q != '0)
                   || ({1'b0, y_reg.r} + {1'b0, ky_reg.r} >= {1'b0, f_reg.output_height}));
    assign row_last = ({1'b0, row_reg} + 1'b1) >= {1'b0, f_reg.output_width};
    assign col_last = ({1'b0, col_reg} + 1'b1) >= {1'b0, f_reg.output_height};

    // one step below the far edge: x = ow-1 (ccw start), y = oh-1 (cw start)
    always_comb
    begin
        acc_t xe;
        acc_t ye;
        xe.q = f_reg.source_width;
        xe.r = '0;
        ye.q = f_reg.source_height;
        ye.r = '0;
        ax_top = step_down(xe, kx_reg.q, kx_reg.r, f_reg.output_width);
        ay_top = step_down(ye, ky_reg.q, ky_reg.r, f_reg.output_height);
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        pix_next    = pix_reg;
        f_next      = f_reg;
        scan_next   = scan_reg;
        kx_next     = kx_reg;
        ky_next     = ky_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        ys_next     = ys_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res_word    = '0;
        div_req     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    pix_next = cmd.pixel;
                    case (cmd.code)
                        rnsb_pkg::CMD_PIXEL:
                        begin
                            if (active_reg)
                            begin
                                state_next = ST_WR;
                            end
                        end
                        rnsb_pkg::CMD_START:
                        begin
                            f_next      = cfg;
                            scan_next   = cfg.scanlines_on
                                       && ({1'b0, cfg.output_height}
                                           >= {cfg.source_height, 1'b0});
                            row_next    = '0;
                            col_next    = '0;
                            active_next = 1'b0;
                            div_req.start    = 1'b1;
                            div_req.dividend = cfg.source_width;
                            div_req.divisor  = cfg.output_width;
                            state_next  = ST_DIVX;
                        end
                        rnsb_pkg::CMD_EMPTY:
                        begin
                            f_next      = cfg;
                            row_next    = '0;
                            col_next    = '0;
                            active_next = 1'b0;
                            state_next  = ST_MARK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                if (!res_full)
                begin
                    res_push            = 1'b1;
                    res_word.kind       = rnsb_pkg::KIND_WRITE;
                    res_word.frame_done = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            ST_DIVX:
            begin
                if (div_rsp.done)
                begin
                    kx_next.q        = div_rsp.quotient;
                    kx_next.r        = div_rsp.remainder;
                    div_req.start    = 1'b1;
                    div_req.dividend = f_reg.source_height;
                    div_req.divisor  = f_reg.output_height;
                    state_next       = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_rsp.done)
                begin
                    ky_next.q  = div_rsp.quotient;
                    ky_next.r  = div_rsp.remainder;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                x_next      = f_reg.rotate_clockwise ? zero_acc : ax_top;
                y_next      = f_reg.rotate_clockwise ? ay_top : zero_acc;
                ys_next     = f_reg.rotate_clockwise ? ay_top : zero_acc;
                active_next = 1'b1;
                state_next  = ST_RD;
            end
            ST_RD:
            begin
                if (!res_full)
                begin
                    res_push               = 1'b1;
                    res_word.kind          = rnsb_pkg::KIND_READ;
                    res_word.source_offset = src_ofs;
                    state_next             = ST_IDLE;
                end
            end
            ST_WR:
            begin
                if (!res_full)
                begin
                    res_push             = 1'b1;
                    res_word.kind        = rnsb_pkg::KIND_WRITE;
                    res_word.dest_offset = dst_ofs;
                    res_word.pixel_out   = dark ? ({1'b0, pix_reg[rnsb_pkg::PIX_W-1:1]}
                                                   & rnsb_pkg::HALF_MASK)
                                                : pix_reg;
                    res_word.frame_done  = row_last && col_last;
                    if (row_last && col_last)
                    begin
                        active_next = 1'b0;
                        row_next    = '0;
                        col_next    = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        if (col_last)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                            y_next   = ys_reg;
                            x_next   = f_reg.rotate_clockwise
                                ? step_up(x_reg, kx_reg.q, kx_reg.r, f_reg.output_width)
                                : step_down(x_reg, kx_reg.q, kx_reg.r, f_reg.output_width);
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                            y_next   = f_reg.rotate_clockwise
                                ? step_down(y_reg, ky_reg.q, ky_reg.r, f_reg.output_height)
                                : step_up(y_reg, ky_reg.q, ky_reg.r, f_reg.output_height);
                        end
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            active_reg <= 1'b0;
            pix_reg    <= '0;
            f_reg      <= '0;
            scan_reg   <= 1'b0;
            kx_reg     <= '0;
            ky_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            ys_reg     <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            pix_reg    <= pix_next;
            f_reg      <= f_next;
            scan_reg   <= scan_next;
            kx_reg     <= kx_next;
            ky_reg     <= ky_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            ys_reg     <= ys_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

    assign active = active_reg;

endmodule

// ===== hdl/rotate_nearest_scale_blit_core.sv =====
`timescale 1ns / 1ps

// Rotating nearest-neighbor scale blitter for RGB565 frames. Write the eight
// size/stride/mode registers while the block is idle, then push a start word
// (mode 0). The block answers with a source read request (kind 0); push the
// fetched pixel back as a pixel word (mode 1) and it returns the destination
// write (kind 1) followed by the read request for the next pixel, walking
// destination rows in order and columns within each row. The last write has
// frame_done set. A zero size or an output height above MAX_OUT_HEIGHT gives
// a single empty-frame word (kind 1, frame_done 1, all else 0). A pixel word
// with no frame running is dropped. A pixel word takes the back-end
// sequencer through the command pop, the write word and any read word, one
// result word per cycle while the 2-word result queue has room. A start takes
// it through the command pop, two runs of the shared bit-serial divider (11
// quotient bits each) for the per-frame step constants, a setup state and
// the first read word; an empty-frame start, through the command pop and
// the empty-frame word. A full result queue stalls the sequencer. Input and
// result sides are decoupled by a 2-word command queue and the result queue.
module rotate_nearest_scale_blit_core #(
    parameter int MAX_OUT_HEIGHT = rnsb_pkg::MAX_OUT_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_write,
    input  logic [rnsb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rnsb_pkg::CFG_DATA_W-1:0] cfg_data,
    // input words
    input  logic                           push,
    output logic                           full,
    input  logic                           mode,
    input  logic [rnsb_pkg::PIX_W-1:0]      pixel_in,
    // result words
    output logic                           empty,
    input  logic                           pop,
    output logic                           kind,
    output logic [rnsb_pkg::OFS_W-1:0]      source_offset,
    output logic [rnsb_pkg::OFS_W-1:0]      dest_offset,
    output logic [rnsb_pkg::PIX_W-1:0]      pixel_out,
    output logic                           frame_done
);

    localparam int W = rnsb_pkg::DIM_W;
    localparam int S = rnsb_pkg::STR_W;

    rnsb_pkg::cfg_t cfg_reg, cfg_next;
    logic           cmd_valid;
    rnsb_pkg::cmd_t cmd;
    logic           cmd_pop;
    logic           res_push;
    rnsb_pkg::res_t res_word;
    rnsb_pkg::res_t res_head;
    logic           res_full;
    logic           back_active;

    // register file, each field masked to its width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                rnsb_pkg::REG_SRC_W:   cfg_next.source_width     = cfg_data[W-1:0];
                rnsb_pkg::REG_SRC_H:   cfg_next.source_height    = cfg_data[W-1:0];
                rnsb_pkg::REG_OUT_W:   cfg_next.output_width     = cfg_data[W-1:0];
                rnsb_pkg::REG_OUT_H:   cfg_next.output_height    = cfg_data[W-1:0];
                rnsb_pkg::REG_ROT_CW:  cfg_next.rotate_clockwise = cfg_data[0];
                rnsb_pkg::REG_SCAN:    cfg_next.scanlines_on     = cfg_data[0];
                rnsb_pkg::REG_SSTRIDE: cfg_next.source_stride    = cfg_data[S-1:0];
                rnsb_pkg::REG_DSTRIDE: cfg_next.dest_stride      = cfg_data[S-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify words, queue commands
    rnsb_front #(
        .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .pixel_in  (pixel_in),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back: frame walk and address generation
    rnsb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_word  (res_word),
        .res_full  (res_full),
        .active    (back_active)
    );

    // result queue toward the consumer
    rnsb_fifo #(
        .WIDTH ($bits(rnsb_pkg::res_t)),
        .DEPTH (rnsb_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_word),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign kind          = res_head.kind;
    assign source_offset = res_head.source_offset;
    assign dest_offset   = res_head.dest_offset;
    assign pixel_out     = res_head.pixel_out;
    assign frame_done    = res_head.frame_done;

`ifndef ASSERT_OFF
    // sequencer never pushes into a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into full queue");

    // frame end word leaves the sequencer idle
    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_word.frame_done) |=> !back_active)
        else $error("frame still active after frame_done word");

    // read requests carry only a source offset
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_word.kind == rnsb_pkg::KIND_READ)
        |-> (res_word.dest_offset == '0 && res_word.pixel_out == '0
             && !res_word.frame_done))
        else $error("read request word carries write fields");
`endif

endmodule

// ===== test/rotate_nearest_scale_blit_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the rotating nearest-neighbor blitter.
// The sender side plays the memory client: start words open a frame and
// pixel words return fetched source pixels. Every accepted word runs through
// an in-bench model of the engine, which queues the result words it should
// produce. The receiver side pops result words under random stalls and
// compares each one, field by field, with the oldest queued expectation.
module rotate_nearest_scale_blit_core_tb;

    localparam int IDLE_MAX     = 18;    // longest per-word idle on either side
    localparam int SETTLE_CYC   = 40;    // settle time for a trailing start
    localparam int STALL_LIMIT  = 3000;  // cycles with no accepted word
    localparam int RANDOM_WORDS = 500;
    localparam int MAX_OH       = rnsb_pkg::MAX_OUT_HEIGHT_DEF;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [rnsb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rnsb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            push = 1'b0;
    logic                            full;
    logic                            mode = rnsb_pkg::MODE_START;
    logic [rnsb_pkg::PIX_W-1:0]      pixel_in = '0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic                            kind;
    logic [rnsb_pkg::OFS_W-1:0]      source_offset;
    logic [rnsb_pkg::OFS_W-1:0]      dest_offset;
    logic [rnsb_pkg::PIX_W-1:0]      pixel_out;
    logic                            frame_done;

    rotate_nearest_scale_blit_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .pixel_in      (pixel_in),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .source_offset (source_offset),
        .dest_offset   (dest_offset),
        .pixel_out     (pixel_out),
        .frame_done    (frame_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Blitter model state: registers as written, the copy latched by the
    // last start, and the destination walk position.
    // ------------------------------------------------------------------
    rnsb_pkg::cfg_t    reg_shadow = '0;
    rnsb_pkg::cfg_t    frame_cfg = '0;
    logic              frame_dark_en = 1'b0;
    logic              frame_on = 1'b0;
    longint unsigned   row_idx = 0;
    longint unsigned   col_idx = 0;
    rnsb_pkg::res_t    expected_words[$];

    // run statistics
    int mismatches = 0;
    int words_checked = 0;
    int words_live = 0;      // sent words that produced results
    int frames_started = 0;
    int empty_frames = 0;
    int dark_writes = 0;

    // flow control state
    bit send_burst = 1'b0;
    bit pop_burst = 1'b0;
    int pop_wait = 0;
    int idle_cycles = 0;

    function automatic void shadow_write(input logic [rnsb_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [rnsb_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rnsb_pkg::REG_SRC_W:   reg_shadow.source_width     = data[rnsb_pkg::DIM_W-1:0];
            rnsb_pkg::REG_SRC_H:   reg_shadow.source_height    = data[rnsb_pkg::DIM_W-1:0];
            rnsb_pkg::REG_OUT_W:   reg_shadow.output_width     = data[rnsb_pkg::DIM_W-1:0];
            rnsb_pkg::REG_OUT_H:   reg_shadow.output_height    = data[rnsb_pkg::DIM_W-1:0];
            rnsb_pkg::REG_ROT_CW:  reg_shadow.rotate_clockwise = data[0];
            rnsb_pkg::REG_SCAN:    reg_shadow.scanlines_on     = data[0];
            rnsb_pkg::REG_SSTRIDE: reg_shadow.source_stride    = data[rnsb_pkg::STR_W-1:0];
            rnsb_pkg::REG_DSTRIDE: reg_shadow.dest_stride      = data[rnsb_pkg::STR_W-1:0];
            default: ;
        endcase
    endfunction

    // A zero size or a too-tall output turns a start into an empty frame.
    function automatic bit frame_is_empty(input rnsb_pkg::cfg_t c);
        return c.source_width == 0 || c.source_height == 0 ||
               c.output_width == 0 || c.output_height == 0 ||
               int'(c.output_height) > MAX_OH;
    endfunction

    // Source row for a destination column; dark marks the last landscape
    // line mapped from that source row when scanlines apply.
    function automatic longint unsigned source_row(input longint unsigned c,
                                                   output logic dark);
        longint unsigned y;
        longint unsigned sy;
        longint unsigned nx;
        y  = frame_cfg.rotate_clockwise ? frame_cfg.output_height - 1 - c : c;
        sy = y * frame_cfg.source_height / frame_cfg.output_height;
        nx = (y + 1) * frame_cfg.source_height / frame_cfg.output_height;
        dark = frame_dark_en && (nx != sy);
        return sy;
    endfunction

    function automatic rnsb_pkg::res_t read_request();
        rnsb_pkg::res_t  w;
        logic            dark;
        longint unsigned xo;
        longint unsigned sx;
        longint unsigned sy;
        w  = '0;
        xo = frame_cfg.rotate_clockwise ? row_idx
                                        : frame_cfg.output_width - 1 - row_idx;
        sx = xo * frame_cfg.source_width / frame_cfg.output_width;
        sy = source_row(col_idx, dark);
        w.kind          = rnsb_pkg::KIND_READ;
        w.source_offset = rnsb_pkg::OFS_W'(sy * frame_cfg.source_stride + sx);
        return w;
    endfunction

    // Advance the model by one accepted word; returns how many result
    // words it queued (0 for a pixel that arrives with no frame running).
    function automatic int blit_predict(input logic m,
                                        input logic [rnsb_pkg::PIX_W-1:0] pix);
        rnsb_pkg::res_t  w;
        logic            dark;
        logic            last;
        if (m == rnsb_pkg::MODE_START)
        begin
            frame_cfg     = reg_shadow;
            frame_dark_en = reg_shadow.scanlines_on &&
                            int'(reg_shadow.output_height) >=
                            2 * int'(reg_shadow.source_height);
            row_idx = 0;
            col_idx = 0;
            frames_started++;
            if (frame_is_empty(frame_cfg))
            begin
                frame_on     = 1'b0;
                w            = '0;
                w.kind       = rnsb_pkg::KIND_WRITE;
                w.frame_done = 1'b1;
                expected_words.push_back(w);
                empty_frames++;
                return 1;
            end
            frame_on = 1'b1;
            expected_words.push_back(read_request());
            return 1;
        end
        if (!frame_on)
            return 0;
        void'(source_row(col_idx, dark));
        last          = (row_idx + 1 >= frame_cfg.output_width) &&
                        (col_idx + 1 >= frame_cfg.output_height);
        w             = '0;
        w.kind        = rnsb_pkg::KIND_WRITE;
        w.dest_offset = rnsb_pkg::OFS_W'(row_idx * frame_cfg.dest_stride + col_idx);
        w.pixel_out   = dark ? ((pix >> 1) & rnsb_pkg::HALF_MASK) : pix;
        w.frame_done  = last;
        expected_words.push_back(w);
        if (dark)
            dark_writes++;
        if (last)
        begin
            frame_on = 1'b0;
            row_idx  = 0;
            col_idx  = 0;
            return 1;
        end
        col_idx++;
        if (col_idx >= frame_cfg.output_height)
        begin
            col_idx = 0;
            row_idx++;
        end
        expected_words.push_back(read_request());
        return 2;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random pop stalls, one check per popped word.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] word %0d %s: got 0x%0h, expected 0x%0h",
                 $time, words_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_word();
        rnsb_pkg::res_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("unexpected word, kind", kind, 0);
        end
        else
        begin
            want = expected_words.pop_front();
            if (kind !== want.kind)
                report_mismatch("kind", kind, want.kind);
            if (source_offset !== want.source_offset)
                report_mismatch("source_offset", source_offset, want.source_offset);
            if (dest_offset !== want.dest_offset)
                report_mismatch("dest_offset", dest_offset, want.dest_offset);
            if (pixel_out !== want.pixel_out)
                report_mismatch("pixel_out", pixel_out, want.pixel_out);
            if (frame_done !== want.frame_done)
                report_mismatch("frame_done", frame_done, want.frame_done);
        end
        words_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                check_word();
                // occasional stretches with no stall at all
                if ($urandom_range(0, 39) == 0)
                    pop_burst = !pop_burst;
                pop_wait = pop_burst ? 0 : $urandom_range(0, IDLE_MAX);
                if (pop_wait != 0)
                    pop <= 1'b0;
            end
            else if (!pop)
            begin
                if (pop_wait > 0)
                    pop_wait--;
                if (pop_wait == 0)
                    pop <= 1'b1;
            end
        end
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d still expected",
                         STALL_LIMIT, expected_words.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side helpers.
    // ------------------------------------------------------------------

    // Send one word after a random idle gap. push stays high on return so a
    // back-to-back word never toggles it within a single time step.
    task automatic send_word(input logic m, input logic [rnsb_pkg::PIX_W-1:0] pix);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        mode     <= m;
        pixel_in <= pix;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (blit_predict(m, pix) > 0)
            words_live++;
    endtask

    // Hold the sender until every expected word has come back; with settle,
    // also give a trailing start or dropped pixel time to clear the engine.
    task automatic wait_results(input bit settle);
        push <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
        if (settle)
            repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rnsb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rnsb_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        shadow_write(idx, data);
    endtask

    task automatic program_frame(input int sw, input int sh, input int ow, input int oh,
                                 input bit cw, input bit scan,
                                 input int sstr, input int dstr);
        write_reg(rnsb_pkg::REG_SRC_W,   rnsb_pkg::CFG_DATA_W'(sw));
        write_reg(rnsb_pkg::REG_SRC_H,   rnsb_pkg::CFG_DATA_W'(sh));
        write_reg(rnsb_pkg::REG_OUT_W,   rnsb_pkg::CFG_DATA_W'(ow));
        write_reg(rnsb_pkg::REG_OUT_H,   rnsb_pkg::CFG_DATA_W'(oh));
        write_reg(rnsb_pkg::REG_ROT_CW,  rnsb_pkg::CFG_DATA_W'(cw));
        write_reg(rnsb_pkg::REG_SCAN,    rnsb_pkg::CFG_DATA_W'(scan));
        write_reg(rnsb_pkg::REG_SSTRIDE, rnsb_pkg::CFG_DATA_W'(sstr));
        write_reg(rnsb_pkg::REG_DSTRIDE, rnsb_pkg::CFG_DATA_W'(dstr));
        cfg_write <= 1'b0;
    endtask

    function automatic logic [rnsb_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return rnsb_pkg::PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly the edges of the range (1, hi, hi - 1), now and then an ordinary size.
    function automatic int pick_size(input int hi);
        case ($urandom_range(0, 3))
            0: return 1;
            1: return hi;
            2: return hi - 1;
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset: a stray pixel is dropped, and a start with all
    // registers at zero gives the empty-frame word.
    task automatic test_reset_state();
        send_word(rnsb_pkg::MODE_PIXEL, 16'hFFFF);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        wait_results(1'b1);
    endtask

    // Two tiny complete frames: clockwise plain, then counterclockwise with
    // scanline halving (output twice the source height). The first one
    // pauses mid-frame until the engine has caught up.
    task automatic test_small_frames();
        program_frame(2, 2, 2, 2, 1'b1, 1'b0, 5, 7);
        send_word(rnsb_pkg::MODE_START, 16'h1234);
        send_word(rnsb_pkg::MODE_PIXEL, 16'h0000);
        send_word(rnsb_pkg::MODE_PIXEL, 16'hFFFF);
        wait_results(1'b0);
        send_word(rnsb_pkg::MODE_PIXEL, 16'h8000);
        send_word(rnsb_pkg::MODE_PIXEL, 16'h5555);
        wait_results(1'b1);
        program_frame(3, 1, 2, 2, 1'b0, 1'b1, 3, 4);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        send_word(rnsb_pkg::MODE_PIXEL, 16'hFFFF);
        send_word(rnsb_pkg::MODE_PIXEL, 16'hFFFF);
        send_word(rnsb_pkg::MODE_PIXEL, 16'h8000);
        send_word(rnsb_pkg::MODE_PIXEL, rnsb_pkg::HALF_MASK);
        wait_results(1'b1);
    endtask

    // Each zero size and an output just over the height limit, then the
    // largest legal output size with full strides, restarted while running.
    task automatic test_size_limits();
        program_frame(0, 4, 4, 4, 1'b1, 1'b0, 9, 9);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        wait_results(1'b1);
        program_frame(4, 0, 4, 4, 1'b1, 1'b1, 9, 9);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        wait_results(1'b1);
        program_frame(4, 4, 0, 4, 1'b0, 1'b0, 9, 9);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        wait_results(1'b1);
        program_frame(4, 4, 4, 0, 1'b0, 1'b1, 9, 9);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        wait_results(1'b1);
        program_frame(4, 4, 4, MAX_OH + 1, 1'b1, 1'b0, 9, 9);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        wait_results(1'b1);
        program_frame(1024, 1024, 2047, MAX_OH, 1'b1, 1'b1, 8191, 8191);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        send_word(rnsb_pkg::MODE_PIXEL, 16'hFFFF);
        send_word(rnsb_pkg::MODE_PIXEL, 16'h0001);
        send_word(rnsb_pkg::MODE_START, 16'h0000);
        send_word(rnsb_pkg::MODE_PIXEL, 16'hFFFE);
        wait_results(1'b1);
    endtask

    // Random phases: new registers, then one to three frames. Most frames
    // are small and run to the end; some are cut short by a restart, some
    // are followed by stray pixels, and large ones only run a few pixels.
    task automatic test_random_frames();
        int base;
        int sw, sh, ow, oh;
        int frames;
        int total;
        int count;
        int style;
        int pause_at;
        base = words_live;
        while (words_live - base < RANDOM_WORDS)
        begin
            wait_results(1'b1);
            sw = $urandom_range(1, 6);
            sh = $urandom_range(1, 4);
            ow = $urandom_range(1, 6);
            oh = $urandom_range(1, 8);
            case ($urandom_range(0, 19))
                0:
                begin
                    case ($urandom_range(0, 4))
                        0: sw = 0;
                        1: sh = 0;
                        2: ow = 0;
                        3: oh = 0;
                        default: oh = $urandom_range(MAX_OH + 1, 2047);
                    endcase
                end
                1, 2:
                begin
                    sw = pick_size(2047);
                    sh = pick_size(2047);
                    ow = pick_size(2047);
                    oh = pick_size(MAX_OH);
                end
                default: ;
            endcase
            program_frame(sw, sh, ow, oh, $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 8191), $urandom_range(0, 8191));
            // raw write with every data bit in play; upper bits are masked
            if ($urandom_range(0, 7) == 0)
            begin
                @(posedge clk);
                write_reg(rnsb_pkg::CFG_IDX_W'($urandom_range(0, 7)),
                          rnsb_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
                cfg_write <= 1'b0;
            end
            frames = $urandom_range(1, 3);
            repeat (frames)
            begin
                total = frame_is_empty(reg_shadow) ? 0 :
                        int'(reg_shadow.output_width) * int'(reg_shadow.output_height);
                style = $urandom_range(0, 9);
                if (total > 64)
                    count = $urandom_range(1, 24);
                else if (style == 0 && total > 0)
                    count = $urandom_range(0, total - 1);
                else if (style == 1)
                    count = total + $urandom_range(1, 3);
                else
                    count = total;
                pause_at = ($urandom_range(0, 9) == 0) ? count / 2 : -1;
                send_word(rnsb_pkg::MODE_START, rand_pixel());
                for (int i = 0; i < count; i++)
                begin
                    if (i == pause_at)
                        wait_results(1'b0);
                    send_word(rnsb_pkg::MODE_PIXEL, rand_pixel());
                end
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_small_frames();
        test_size_limits();
        test_random_frames();

        wait_results(1'b1);
        $display("Run covered %0d frame starts (%0d empty) and %0d live input words;",
                 frames_started, empty_frames, words_live);
        $display("checked %0d result words, %0d of them halved scanline pixels.",
                 words_checked, dark_writes);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
